// ----- hw/rtl/rlre_pkg.sv -----
// Shared types and constants of the ranked-list local rank error block.
`default_nettype none

package rlre_pkg;

  localparam int RANK_W   = 12;
  localparam int WGT_W    = 9;
  localparam int LEN_W    = 13;
  localparam int SCORE_W  = 18;
  localparam int ERR_W    = 48;
  localparam int STEP_W   = 5;
  localparam int LOG_FRAC = 30;
  localparam int QUO_BITS = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [WGT_W-1:0] WGT_RESET = 9'd128;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_REL_WEIGHT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRED_WEIGHT = 1'b1;

  localparam logic [STEP_W-1:0] LOG_STEP_LAST = 5'd29;
  localparam logic [STEP_W-1:0] QUO_STEP_LAST = 5'd16;

  localparam logic [SCORE_W-1:0] SCORE_ONE     = 18'h10000;
  localparam logic [SCORE_W-1:0] SCORE_NEG_ONE = 18'h30000;

  typedef struct packed {
    logic              load_in;
    logic              prod_mul;
    logic              log_init;
    logic              log_step;
    logic              div_init;
    logic              div_step;
    logic              x_load;
    logic              frac_mul;
    logic              err_acc;
    logic              adv;
    logic              norm_init;
    logic              norm_acc;
    logic              cmp_init;
    logic              quo_step;
    logic              out_load;
    logic              norm_mode;
    logic [STEP_W-1:0] step;
  } rlre_cmd_t;

  typedef struct packed {
    logic pair_need;
    logic last;
    logic n_small;
    logic j_last;
    logic big;
    logic out_free;
  } rlre_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ranked_list_local_rank_error.sv -----
// Top level of the normalised local rank error block over a ranked list.
//
// Use: feed one list item per input word (in_rel_rank, in_cred_rank, in_last_item)
// on a valid/ready channel. Each word adds the weighted rank-drop error of the
// pair (previous, current) scaled by 1/log2(position+1). The word marked last
// closes the list: the normaliser for its length is summed, the score
// 1 - error/normaliser (signed Q16) is formed and one result word
// (out_nlre_score, out_list_length) is presented on the output channel.
// An item with a pair to score runs 30 squaring steps for log2, FRAC_BITS+1 divide
// steps for its reciprocal and three multiply and add steps; the first item of a
// list and items past MAX_ITEMS skip them. A last item of a list longer than three
// then sums floor(n/2) normaliser terms (same shared log2/reciprocal unit, one term
// at a time) and runs the score divider. One item is in work at a time; in_ready is
// high only when idle. The result sits in an output register: a stalled receiver
// holds the block only when the next list finishes before the old word is taken.
// Weights are written on the cfg channel (always ready); the user writes them only
// while idle, which the block does not enforce. Reset (rst_n low, synchronous)
// clears the list state and sets both weights to 128.
`default_nettype none

module ranked_list_local_rank_error import rlre_pkg::*; #(
  parameter int MAX_ITEMS = 4096,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [RANK_W-1:0]    in_rel_rank,
  input  wire logic [RANK_W-1:0]    in_cred_rank,
  input  wire logic                 in_last_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [SCORE_W-1:0] out_nlre_score,
  output logic [LEN_W-1:0]          out_list_length,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WGT_W-1:0]     cfg_wdata
);

  rlre_cmd_t          cmd;
  rlre_sts_t          st;
  logic [SCORE_W-1:0] score;

  // weights are plain registers: take a write every cycle
  assign cfg_ready = 1'b1;

  rlre_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rlre_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_rel_rank  (in_rel_rank),
    .in_cred_rank (in_cred_rank),
    .in_last_item (in_last_item),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_score    (score),
    .out_len      (out_list_length)
  );

  assign out_nlre_score = signed'(score);

endmodule

`default_nettype wire

// ----- hw/rtl/rlre_ctrl.sv -----
// Sequencer of the local rank error block: steps the datapath per item and per list.
`default_nettype none

module rlre_ctrl import rlre_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rlre_sts_t st,
  output rlre_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_LOGI = 4'd2;
  localparam logic [3:0] S_LOGS = 4'd3;
  localparam logic [3:0] S_DIVI = 4'd4;
  localparam logic [3:0] S_DIVS = 4'd5;
  localparam logic [3:0] S_FMUL = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_ADV  = 4'd8;
  localparam logic [3:0] S_NCHK = 4'd9;
  localparam logic [3:0] S_NACC = 4'd10;
  localparam logic [3:0] S_CMP  = 4'd11;
  localparam logic [3:0] S_QUO  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              norm_r, norm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      norm_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      norm_r  <= norm_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    norm_nxt      = norm_r;
    cmd           = '0;
    cmd.norm_mode = norm_r;
    cmd.step      = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        norm_nxt  = 1'b0;
        state_nxt = st.pair_need ? S_LOGI : S_ADV;
      end
      S_LOGI: begin
        cmd.log_init = 1'b1;
        cmd.prod_mul = 1'b1;
        step_nxt     = LOG_STEP_LAST;
        state_nxt    = S_LOGS;
      end
      S_LOGS: begin
        cmd.log_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_DIVI;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cmd.x_load   = 1'b1;
        step_nxt     = STEP_W'(FRAC_BITS);
        state_nxt    = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_FMUL;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_FMUL: begin
        cmd.frac_mul = 1'b1;
        state_nxt    = norm_r ? S_NACC : S_ACC;
      end
      S_ACC: begin
        cmd.err_acc = 1'b1;
        state_nxt   = S_ADV;
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = st.last ? S_NCHK : S_IDLE;
      end
      S_NCHK: begin
        cmd.norm_init = 1'b1;
        norm_nxt      = 1'b1;
        state_nxt     = st.n_small ? S_CMP : S_LOGI;
      end
      S_NACC: begin
        cmd.norm_acc = 1'b1;
        state_nxt    = st.j_last ? S_CMP : S_LOGI;
      end
      S_CMP: begin
        cmd.cmp_init = 1'b1;
        step_nxt     = QUO_STEP_LAST;
        state_nxt    = st.big ? S_OUT : S_QUO;
      end
      S_QUO: begin
        cmd.quo_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rlre_dp.sv -----
// Datapath of the local rank error block: list state, log2 reciprocal, products, divider.
`default_nettype none

module rlre_dp import rlre_pkg::*; #(
  parameter int MAX_ITEMS = 4096,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rlre_cmd_t            cmd,
  output rlre_sts_t                 st,
  input  wire logic [RANK_W-1:0]    in_rel_rank,
  input  wire logic [RANK_W-1:0]    in_cred_rank,
  input  wire logic                 in_last_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WGT_W-1:0]     cfg_wdata,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [SCORE_W-1:0]        out_score,
  output logic [LEN_W-1:0]          out_len
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int EW     = $clog2(CNT_W + 1);
  localparam int LGW    = EW + LOG_FRAC;
  localparam int T_W    = (2 * CNT_W + 9 > 42) ? 2 * CNT_W + 9 : 42;
  localparam int XW     = T_W + FRAC_BITS;
  localparam int HP_W   = T_W + FRAC_BITS + 1;
  localparam int LP_W   = 2 * FRAC_BITS + 1;
  localparam int TERM_W = T_W + FRAC_BITS + 2;
  localparam int CW     = 3 * CNT_W + FRAC_BITS;
  localparam int PA_W   = T_W;
  localparam int PB_W   = (10 + CNT_W > 18) ? 10 + CNT_W : 18;
  localparam int SH_L   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int NSH    = FRAC_BITS - 8;
  localparam int AW     = ((TERM_W > ERR_W) ? TERM_W : ERR_W) + 1;
  localparam int DW     = ((CW + 1 > ERR_W) ? CW + 1 : ERR_W) + 1;
  localparam int NW     = FRAC_BITS + LOG_FRAC + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  // list state
  logic [RANK_W-1:0] rel_r, cred_r, prev_rel_r, prev_cred_r;
  logic              last_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ERR_W-1:0]  err_r;
  logic [WGT_W-1:0]  wrel_r, wcred_r;
  // reciprocal unit
  logic [LOG_FRAC:0]  y_r;
  logic [LGW-1:0]     lg_r, drem_r;
  logic [FRAC_BITS:0] dnum_r, recip_r;
  // products
  logic [PA_W-1:0] pa_r;
  logic [PB_W-1:0] pb_r;
  logic [XW-1:0]   x_r;
  logic [HP_W-1:0] hp_r;
  logic [LP_W-1:0] lp_r;
  // normaliser and score
  logic [CNT_W-1:0]    j_r;
  logic [CW-1:0]       csum_r;
  logic                big_r;
  logic [CW:0]         qrem_r;
  logic [QUO_BITS-1:0] q_r;
  logic [SCORE_W-1:0]  score_r;
  logic [LEN_W-1:0]    len_r;
  logic                ovalid_r;

  logic [CNT_W-1:0]          p_sel, m_val;
  logic [EW-1:0]             e_val;
  logic [CNT_W+LOG_FRAC-1:0] ysh;
  logic [61:0]               sq;
  logic [31:0]               sqs;
  logic [NW-1:0]             numv;
  logic [LGW:0]              rem2;
  logic                      dge;
  logic [RANK_W-1:0]         er, ec;
  logic [20:0]               fa, fb;
  logic [WGT_W:0]            wsum;
  logic [PA_W-1:0]           p16;
  logic [XW-1:0]             t8;
  logic [TERM_W-1:0]         term;
  logic [AW-1:0]             term_a, room;
  logic [DW-1:0]             errx, c2;
  logic                      big_c, qge;
  logic [CW:0]               qdiff;

  always_comb begin
    p_sel = cmd.norm_mode ? CNT_W'({j_r, 1'b0} + (CNT_W + 1)'(2)) : cnt_r + CNT_W'(1);
    e_val = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (p_sel[i]) e_val = EW'(i);
    end
    ysh  = {p_sel, {LOG_FRAC{1'b0}}} >> e_val;
    sq   = 62'(y_r) * 62'(y_r);
    sqs  = sq[61:30];
    numv = (NW'(1) << (FRAC_BITS + LOG_FRAC)) + NW'(lg_r >> 1);
    rem2 = {drem_r, dnum_r[FRAC_BITS]};
    dge  = rem2 >= {1'b0, lg_r};
    er   = (prev_rel_r > rel_r) ? prev_rel_r - rel_r : '0;
    ec   = (prev_cred_r > cred_r) ? prev_cred_r - cred_r : '0;
    fa   = {1'b0, er, 8'b0} + 21'(wrel_r);
    fb   = {1'b0, ec, 8'b0} + 21'(wcred_r);
    wsum = {1'b0, wrel_r} + {1'b0, wcred_r};
    m_val = cnt_r - CNT_W'({j_r, 1'b0}) - CNT_W'(1);
    p16  = pa_r - PA_W'(pb_r);
    t8   = (XW'(pa_r) << 8) + XW'(pb_r);
    term = TERM_W'(hp_r) + TERM_W'(lp_r >> FRAC_BITS);
    term_a = AW'(term);
    room   = AW'({ERR_W{1'b1}}) - AW'(err_r);
    errx   = DW'(err_r);
    c2     = DW'(csum_r) << 1;
    big_c  = errx >= c2;
    qge    = qrem_r >= {1'b0, csum_r};
    qdiff  = qge ? qrem_r - {1'b0, csum_r} : qrem_r;
  end

  // list state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrel_r      <= WGT_RESET;
      wcred_r     <= WGT_RESET;
      prev_rel_r  <= '0;
      prev_cred_r <= '0;
      cnt_r       <= '0;
      err_r       <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REL_WEIGHT:  wrel_r  <= cfg_wdata;
          CFG_CRED_WEIGHT: wcred_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.err_acc) begin
        err_r <= (term_a >= room) ? {ERR_W{1'b1}} : ERR_W'(AW'(err_r) + term_a);
      end
      if (cmd.adv && (cnt_r < CNT_MAX)) begin
        prev_rel_r  <= rel_r;
        prev_cred_r <= cred_r;
        cnt_r       <= cnt_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        prev_rel_r  <= '0;
        prev_cred_r <= '0;
        cnt_r       <= '0;
        err_r       <= '0;
        ovalid_r    <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rel_r  <= in_rel_rank;
      cred_r <= in_cred_rank;
      last_r <= in_last_item;
    end
    if (cmd.log_init) begin
      y_r  <= ysh[LOG_FRAC:0];
      lg_r <= LGW'(e_val) << LOG_FRAC;
    end
    if (cmd.log_step) begin
      y_r <= sqs[31] ? sqs[31:1] : sqs[30:0];
      if (sqs[31]) lg_r <= lg_r | (LGW'(1) << cmd.step);
    end
    if (cmd.div_init) begin
      drem_r <= LGW'(numv >> (FRAC_BITS + 1));
      dnum_r <= numv[FRAC_BITS:0];
    end
    if (cmd.div_step) begin
      drem_r  <= dge ? LGW'(rem2 - {1'b0, lg_r}) : rem2[LGW-1:0];
      dnum_r  <= {dnum_r[FRAC_BITS-1:0], 1'b0};
      recip_r <= {recip_r[FRAC_BITS-1:0], dge};
    end
    if (cmd.prod_mul) begin
      if (cmd.norm_mode) begin
        pa_r <= PA_W'(m_val) * PA_W'(m_val);
        pb_r <= PB_W'(wsum) * PB_W'(m_val);
      end else begin
        pa_r <= PA_W'(fa) * PA_W'(fb);
        pb_r <= PB_W'(wrel_r) * PB_W'(wcred_r);
      end
    end
    if (cmd.x_load) begin
      x_r <= cmd.norm_mode ? (t8 << NSH) : ((XW'(p16) << SH_L) >> SH_R);
    end
    if (cmd.frac_mul) begin
      hp_r <= HP_W'(x_r[XW-1:FRAC_BITS]) * HP_W'(recip_r);
      lp_r <= LP_W'(x_r[FRAC_BITS-1:0]) * LP_W'(recip_r);
    end
    if (cmd.norm_init) begin
      j_r <= '0;
      if (cnt_r <= CNT_W'(2)) begin
        csum_r <= CW'(1) << FRAC_BITS;
      end else if (cnt_r == CNT_W'(3)) begin
        csum_r <= CW'(2) << FRAC_BITS;
      end else begin
        csum_r <= '0;
      end
    end
    if (cmd.norm_acc) begin
      csum_r <= csum_r + CW'(term);
      j_r    <= j_r + CNT_W'(1);
    end
    if (cmd.cmp_init) begin
      big_r  <= big_c;
      qrem_r <= errx[CW:0];
      q_r    <= '0;
    end
    if (cmd.quo_step) begin
      qrem_r <= {qdiff[CW-1:0], 1'b0};
      q_r    <= {q_r[QUO_BITS-2:0], qge};
    end
    if (cmd.out_load) begin
      score_r <= big_r ? SCORE_NEG_ONE : SCORE_ONE - SCORE_W'(q_r);
      len_r   <= LEN_W'(cnt_r);
    end
  end

  always_comb begin
    st.pair_need = (cnt_r != '0) && (cnt_r < CNT_MAX);
    st.last      = last_r;
    st.n_small   = cnt_r <= CNT_W'(3);
    st.j_last    = j_r == ((cnt_r >> 1) - CNT_W'(1));
    st.big       = big_c;
    st.out_free  = !ovalid_r || out_ready;
  end

  assign out_valid = ovalid_r;
  assign out_score = score_r;
  assign out_len   = len_r;

  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.log_step) |-> y_r[LOG_FRAC])
    else $error("log mantissa left [1,2)");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.div_step) |-> drem_r < lg_r)
    else $error("reciprocal remainder not below divisor");
  a_quo_rem: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.quo_step) |-> qrem_r < ({1'b0, csum_r} << 1))
    else $error("score remainder out of range");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovalid_r || out_ready))
    else $error("result word overwritten before taken");

endmodule

`default_nettype wire
